### design/bwalu_pkg.sv
// package for the byte width alu: opcodes, status codes, transaction structs
// no dependencies

package bwalu_pkg;

   localparam logic [7:0] OP_MOVE  = 8'h00;
   localparam logic [7:0] OP_CLEAR = 8'h01;
   localparam logic [7:0] OP_COMP  = 8'h02;
   localparam logic [7:0] OP_SUB   = 8'h03;
   localparam logic [7:0] OP_ADD   = 8'h04;
   localparam logic [7:0] OP_MULT  = 8'h05;
   localparam logic [7:0] OP_DIV   = 8'h06;
   localparam logic [7:0] OP_AND   = 8'h07;
   localparam logic [7:0] OP_OR    = 8'h08;
   localparam logic [7:0] OP_XOR   = 8'h09;
   localparam logic [7:0] OP_NOT   = 8'h0A;
   localparam logic [7:0] OP_ASR   = 8'h18;
   localparam logic [7:0] OP_LSL   = 8'h19;
   localparam logic [7:0] OP_LSR   = 8'h1A;
   localparam logic [7:0] OP_LSL2  = 8'h1B;
   localparam logic [7:0] OP_ADDC  = 8'h49;
   localparam logic [7:0] OP_SUBC  = 8'h4A;
   localparam logic [7:0] OP_TEST  = 8'h6A;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIV0    = 2'd1;
   localparam logic [1:0] ST_DIV0_NT = 2'd2;
   localparam logic [1:0] ST_ILLEGAL = 2'd3;

   typedef enum logic [1:0] {
      CLS_SIMPLE,
      CLS_MULT,
      CLS_DIV,
      CLS_ILLEGAL
   } class_type;

   typedef struct packed {
      logic [7:0]  cmd;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic [2:0]  width_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] main_value;
      logic        main_write;
      logic [31:0] extra_value;
      logic        extra_write;
      logic        zero_flag;
      logic        sign_flag;
      logic        carry_flag;
      logic        overflow_flag;
      logic [1:0]  status;
   } rsp_type;

   // classified transaction between front and back
   typedef struct packed {
      req_type     req;
      class_type   cls;
      logic [1:0]  wsel;
   } item_type;

endpackage

### design/bwalu_front.sv
// front end: accepts request transactions, clamps width and classifies opcode
// depends on bwalu_pkg

module bwalu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bwalu_pkg::req_type   req_data,
   output logic                 q_valid,
   input  logic                 q_stall,
   output bwalu_pkg::item_type  q_data
);
   import bwalu_pkg::*;

   logic     full_ff, full_in;
   item_type item_ff, item_in;
   item_type cls_w;

   // classify opcode and clamp width to 1..4 (stored as width-1)
   always_comb begin
      cls_w = '0;
      cls_w.req = req_data;
      unique case (req_data.width_bytes)
         3'd0, 3'd1: cls_w.wsel = 2'd0;
         3'd2:       cls_w.wsel = 2'd1;
         3'd3:       cls_w.wsel = 2'd2;
         default:    cls_w.wsel = 2'd3;
      endcase
      unique case (req_data.cmd)
         OP_MOVE, OP_CLEAR, OP_COMP, OP_SUB, OP_ADD, OP_AND, OP_OR, OP_XOR,
         OP_NOT, OP_ASR, OP_LSL, OP_LSR, OP_LSL2, OP_ADDC, OP_SUBC,
         OP_TEST: cls_w.cls = CLS_SIMPLE;
         OP_MULT: cls_w.cls = CLS_MULT;
         OP_DIV:  cls_w.cls = CLS_DIV;
         default: cls_w.cls = CLS_ILLEGAL;
      endcase
   end

   assign req_stall = full_ff && q_stall;
   assign q_valid   = full_ff;
   assign q_data    = item_ff;

   // single entry queue to the back end
   always_comb begin
      full_in = full_ff;
      item_in = item_ff;
      if (full_ff && !q_stall) begin
         full_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         full_in = 1'b1;
         item_in = cls_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      item_ff <= item_in;
   end

endmodule

### design/bwalu_div.sv
// radix 2 restoring divider on 32-bit magnitudes, one quotient bit per cycle
// depends on bwalu_pkg

module bwalu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   import bwalu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### design/bwalu_back.sv
// back end: executes classified transactions, holds flags, drives result register
// depends on bwalu_pkg and bwalu_div

module bwalu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 trap_mask,
   input  logic                 q_valid,
   output logic                 q_stall,
   input  bwalu_pkg::item_type  q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bwalu_pkg::rsp_type   rsp_data
);
   import bwalu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_DIVW,
      S_OUT
   } state_type;

   state_type   state_ff;
   item_type    cur_ff;
   logic [3:0]  flags_ff;    // {v, c, s, z}
   rsp_type     rsp_ff;
   logic [63:0] prod_ff;
   logic        na_ff, nb_ff;

   logic [31:0] m, sm, am, bm;
   logic [5:0]  bits;
   logic        cin;
   rsp_type     simple_r;
   logic [3:0]  simple_f;
   logic [32:0] sub_w, add_w;
   logic [63:0] sum64;
   logic [31:0] r_w;
   logic        c_w;
   logic [63:0] sa, sb;
   logic        div_start, div_done;
   logic [31:0] div_q, div_r, ua, ub, qv, rv;
   item_type    it;

   assign it = (state_ff == S_IDLE) ? q_data : cur_ff;

   // width masks
   always_comb begin
      unique case (it.wsel)
         2'd0: begin m = 32'h0000_00FF; sm = 32'h0000_0080; bits = 6'd8;  end
         2'd1: begin m = 32'h0000_FFFF; sm = 32'h0000_8000; bits = 6'd16; end
         2'd2: begin m = 32'h00FF_FFFF; sm = 32'h0080_0000; bits = 6'd24; end
         default: begin m = 32'hFFFF_FFFF; sm = 32'h8000_0000; bits = 6'd32; end
      endcase
      am  = it.req.operand_a & m;
      bm  = it.req.operand_b & m;
      cin = flags_ff[2];
   end

   // simple ops, computed combinationally
   always_comb begin
      logic [31:0] b;
      logic        neg, sg;
      logic [63:0] sx;
      b        = it.req.operand_b;
      simple_r = '0;
      simple_f = flags_ff;
      sub_w    = '0;
      add_w    = '0;
      sum64    = '0;
      r_w      = '0;
      c_w      = 1'b0;
      neg      = b[31];
      sg       = (am & sm) != 0;
      sx       = sg ? ({32'hFFFF_FFFF, am} | {32'hFFFF_FFFF, ~m}) : {32'd0, am};
      simple_r.main_write = 1'b1;
      unique case (it.req.cmd)
         OP_MOVE: begin
            r_w = bm;
            simple_f = {1'b0, 1'b0, (r_w & sm) != 0, r_w == 0};
         end
         OP_CLEAR: begin
            r_w = '0;
            simple_f = 4'b0001;
         end
         OP_COMP, OP_SUB, OP_SUBC: begin
            sub_w = {1'b0, am} - {1'b0, bm}
                    - {32'd0, (it.req.cmd == OP_SUBC) ? cin : 1'b0};
            r_w = sub_w[31:0] & m;
            simple_r.main_write = (it.req.cmd != OP_COMP);
            simple_f = {(((am ^ bm) & (am ^ r_w) & sm) != 0), sub_w[32],
                        (r_w & sm) != 0, r_w == 0};
         end
         OP_ADD, OP_ADDC: begin
            add_w = {1'b0, am} + {1'b0, bm}
                    + {32'd0, (it.req.cmd == OP_ADDC) ? cin : 1'b0};
            r_w = add_w[31:0] & m;
            c_w = ((add_w & ~{1'b0, m}) != 0);
            simple_f = {(((am ^ r_w) & (bm ^ r_w) & sm) != 0), c_w,
                        (r_w & sm) != 0, r_w == 0};
         end
         OP_AND, OP_OR, OP_XOR, OP_NOT, OP_TEST: begin
            unique case (it.req.cmd)
               OP_OR:   r_w = am | bm;
               OP_XOR:  r_w = am ^ bm;
               OP_NOT:  r_w = ~am & m;
               default: r_w = am & bm;
            endcase
            simple_r.main_write = (it.req.cmd != OP_TEST);
            simple_f = {1'b0, flags_ff[2], (r_w & sm) != 0, r_w == 0};
         end
         default: begin
            // shifts
            r_w = am;
            if (!neg && b != 0) begin
               if (it.req.cmd == OP_ASR) begin
                  if (b >= {26'd0, bits}) begin
                     r_w = sg ? m : '0;
                     c_w = sg;
                  end else begin
                     c_w = am[b[4:0] - 5'd1];
                     sum64 = sx >> b[4:0];
                     r_w = sum64[31:0] & m;
                  end
               end else if (it.req.cmd == OP_LSR) begin
                  if (b <= {26'd0, bits}) c_w = sx[b[5:0] - 6'd1] & (b[5:0] <= bits);
                  r_w = (b >= {26'd0, bits}) ? '0 : (am >> b[4:0]);
               end else begin
                  if (b <= {26'd0, bits}) c_w = sx[bits - b[5:0]];
                  r_w = (b >= {26'd0, bits}) ? '0 : ((am << b[4:0]) & m);
               end
            end
            simple_f = {1'b0, c_w, (r_w & sm) != 0, r_w == 0};
         end
      endcase
      simple_r.main_value = r_w;
   end

   // sign extended multiply operands
   assign sa = ((it.req.operand_a & sm) != 0) ? {32'hFFFF_FFFF, am | ~m} : {32'd0, am};
   assign sb = ((it.req.operand_b & sm) != 0) ? {32'hFFFF_FFFF, bm | ~m} : {32'd0, bm};

   assign ua = it.req.operand_a[31] ? (32'd0 - it.req.operand_a) : it.req.operand_a;
   assign ub = it.req.operand_b[31] ? (32'd0 - it.req.operand_b) : it.req.operand_b;
   assign div_start = (state_ff == S_DIV);

   bwalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ua),
      .divisor   (ub),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign qv = (na_ff != nb_ff) ? (32'd0 - div_q) : div_q;
   assign rv = na_ff ? (32'd0 - div_r) : div_r;

   assign q_stall   = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // sequencer, flags and result register
   always_ff @(posedge clock) begin
      logic [63:0] sh;
      logic [31:0] lo;
      rsp_type     nr;
      nr = rsp_ff;
      if (reset) begin
         state_ff <= S_IDLE;
         flags_ff <= 4'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff <= q_data;
                  nr = '0;
                  unique case (q_data.cls)
                     CLS_SIMPLE: begin
                        flags_ff <= simple_f;
                        nr = simple_r;
                        {nr.overflow_flag, nr.carry_flag,
                         nr.sign_flag, nr.zero_flag} = simple_f;
                        state_ff <= S_OUT;
                     end
                     CLS_MULT: begin
                        prod_ff  <= $signed(sa[32:0]) * $signed(sb[32:0]);
                        state_ff <= S_MUL;
                     end
                     CLS_DIV: begin
                        na_ff <= q_data.req.operand_a[31];
                        nb_ff <= q_data.req.operand_b[31];
                        if (q_data.req.operand_b == 32'd0) begin
                           nr.status = trap_mask ? ST_DIV0_NT : ST_DIV0;
                           {nr.overflow_flag, nr.carry_flag,
                            nr.sign_flag, nr.zero_flag} = flags_ff;
                           state_ff <= S_OUT;
                        end else begin
                           state_ff <= S_DIV;
                        end
                     end
                     default: begin
                        nr.status = ST_ILLEGAL;
                        {nr.overflow_flag, nr.carry_flag,
                         nr.sign_flag, nr.zero_flag} = flags_ff;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_MUL: begin
               lo = prod_ff[31:0] & m;
               sh = prod_ff >> bits;
               nr.main_value    = lo;
               nr.main_write    = 1'b1;
               nr.extra_value   = sh[31:0] & m;
               nr.extra_write   = 1'b1;
               nr.zero_flag     = (lo == 0);
               nr.sign_flag     = (lo & sm) != 0;
               nr.carry_flag    = flags_ff[2];
               nr.overflow_flag = 1'b0;
               flags_ff <= {1'b0, flags_ff[2], (lo & sm) != 0, lo == 0};
               state_ff <= S_OUT;
            end
            S_DIV: begin
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done) begin
                  lo = qv & m;
                  nr.main_value    = lo;
                  nr.main_write    = 1'b1;
                  nr.extra_value   = rv & m;
                  nr.extra_write   = 1'b1;
                  nr.zero_flag     = (lo == 0);
                  nr.sign_flag     = (lo & sm) != 0;
                  nr.carry_flag    = flags_ff[2];
                  nr.overflow_flag = 1'b0;
                  flags_ff <= {1'b0, flags_ff[2], (lo & sm) != 0, lo == 0};
                  state_ff <= S_OUT;
               end
            end
            default: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
         endcase
      end
      rsp_ff <= nr;
   end

endmodule

### design/byte_width_alu_with_flags.sv
// top level of the byte width alu with flags: csr port, front end, back end
// depends on bwalu_pkg, bwalu_front, bwalu_back
//
//   port group   direction   transaction
//   req_         in          cmd, operand_a, operand_b, width_bytes
//   rsp_         out         values, write enables, flags, status
//   csr_         in/out      trap_mask_enabled at address 0
//
// a simple op goes from the front queue straight to S_OUT, a mult via S_MUL and a
// div via S_DIV (load), 32 one-bit divider steps in S_DIVW and the done flag and
// handoff; the back end takes the next transaction once it is back in S_IDLE
// reset is synchronous and clears flags, trap mask and all valid state
// the front queue holds one transaction while the back end is busy or stalled

module byte_width_alu_with_flags (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bwalu_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bwalu_pkg::rsp_type  rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [0:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import bwalu_pkg::*;

   logic     trap_ff;
   logic     q_valid, q_stall;
   item_type q_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {31'd0, trap_ff} : 32'd0;

   // trap mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         trap_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0) begin
         trap_ff <= csr_pwdata[0];
      end
   end

   bwalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_stall   (q_stall),
      .q_data    (q_data)
   );

   bwalu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .trap_mask (trap_ff),
      .q_valid   (q_valid),
      .q_stall   (q_stall),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
